// ===== rtl/core/mips_eu_pkg.sv =====
// Shared types and constants for the MIPS R3000 subset execute unit.
// Opcode, function and coprocessor codes, result status and fault codes.
// No dependencies.
`default_nettype none

package mips_eu_pkg;

  localparam int XLEN      = 32;
  localparam int REG_COUNT = 32;
  localparam int IDX_W     = 5;

  localparam logic [XLEN-1:0] RESET_PC    = 32'hBFC0_0000;
  localparam int              ISOLATE_BIT = 16;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  // cop0
  localparam logic [4:0] COP0_MT     = 5'd4;
  localparam logic [4:0] C0_BPC      = 5'd3;
  localparam logic [4:0] C0_BDA      = 5'd5;
  localparam logic [4:0] C0_JUMPDEST = 5'd6;
  localparam logic [4:0] C0_DCIC     = 5'd7;
  localparam logic [4:0] C0_BDAM     = 5'd9;
  localparam logic [4:0] C0_BPCM     = 5'd11;
  localparam logic [4:0] C0_SR       = 5'd12;
  localparam logic [4:0] C0_CAUSE    = 5'd13;

  localparam logic [2:0] BYTES_NONE = 3'd0;
  localparam logic [2:0] BYTES_1    = 3'd1;
  localparam logic [2:0] BYTES_2    = 3'd2;
  localparam logic [2:0] BYTES_4    = 3'd4;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_STORE = 2'd1,
    ST_LOAD  = 2'd2,
    ST_FAULT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    F_NONE      = 3'd0,
    F_UNALIGNED = 3'd1,
    F_UNKNOWN   = 3'd2,
    F_COP0_REG  = 3'd3,
    F_OVERFLOW  = 3'd4,
    F_BREAK_WR  = 3'd5
  } fault_t;

endpackage

`default_nettype wire

// ===== rtl/core/mips_eu_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// Read returns the contents before a write at the same edge. No dependencies.
`default_nettype none

module mips_eu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mips_r3000_subset_execute_unit.sv =====
// Top level of the MIPS R3000 subset execute unit: input register, decode/ALU,
// result register, register file in two RAM banks. Uses mips_eu_pkg, mips_eu_ram.
`default_nettype none

// One transaction per clock: a step (execute with the fetched word, or load data
// delivery) is taken into an input register, worked out combinationally against the
// architectural state and written to the result register once that register is
// free, and a new input is taken every cycle while the result side keeps up.
// A waiting result holds the input register, so while out_tready stays low at most
// one further input is taken before in_tready drops. The register file sits in two
// RAM banks, one written by instructions and one by landing loads, with a
// per-register valid bit and a bank-select bit in flip-flops; operands are read
// ahead through the registered read ports from the word being held as the next
// instruction, with the writes of the step in between forwarded. Reset needs no
// clearing pass.

module mips_r3000_subset_execute_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // [31:0] word
  input  wire logic         in_tuser,   // [0] action
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [103:0] out_tdata,  // [2:0] access_bytes, [34:3] address,
                                        // [66:35] store_data, [98:67] fetch_address,
                                        // [101:99] fault_code, [103:102] zero
  output logic      [1:0]   out_tuser   // [1:0] status
);

  localparam int XL = mips_eu_pkg::XLEN;
  localparam int IW = mips_eu_pkg::IDX_W;

  // input register
  logic          s1_v_r, s1_v_nxt;
  logic          s1_act_r;
  logic [XL-1:0] s1_word_r;
  logic          adv, exec, deliver, accept;

  // architectural state
  logic [XL-1:0] pc_r, pc_nxt;
  logic [XL-1:0] sr_r, sr_nxt;
  logic [XL-1:0] held_r, held_nxt;
  logic [IW-1:0] dl_t_r, dl_t_nxt;
  logic [XL-1:0] dl_v_r, dl_v_nxt;
  logic [IW-1:0] pend_t_r, pend_t_nxt;
  logic          pend_r, pend_nxt;
  logic [mips_eu_pkg::REG_COUNT-1:0] vld_r, vld_nxt;
  logic [mips_eu_pkg::REG_COUNT-1:0] lvt_r, lvt_nxt;

  // operand read path
  logic [2*IW-1:0] rd_src;
  logic [IW-1:0] ra_s, ra_t;
  logic          rs_vld_r, rs_lvt_r, rt_vld_r, rt_lvt_r;
  logic [XL-1:0] rda_s, rda_t, rdb_s, rdb_t;
  logic          fa_v_r, fa_v_nxt, fb_v_r, fb_v_nxt;
  logic [IW-1:0] fa_idx_r, fb_idx_r;
  logic [XL-1:0] fa_val_r, fb_val_r;

  // result register
  logic                 out_v_r, out_v_nxt;
  mips_eu_pkg::status_t out_status_r, o_status;
  mips_eu_pkg::fault_t  out_fault_r, o_fault;
  logic [2:0]           out_bytes_r, o_bytes;
  logic [XL-1:0]        out_addr_r, o_addr;
  logic [XL-1:0]        out_sdata_r, o_sdata;
  logic [XL-1:0]        out_fetch_r, o_fetch;

  // decode and execute
  logic [5:0]    op, fn;
  logic [IW-1:0] rs, rt, rd, sa;
  logic [15:0]   imm;
  logic [XL-1:0] ise, opa, opb, pc_plus, sum_i, ea;
  logic          ovf, mis, isolated;
  logic [2:0]    w_bytes;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [XL-1:0] wr_val;
  logic          sr_we, load_issue;
  logic          land_en, inst_en;

  // ---------------------------------------------------------------------------
  // handshake
  assign adv       = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv;
  assign accept    = in_tvalid && in_tready;
  assign exec      = adv && !s1_act_r;
  assign deliver   = adv && s1_act_r;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act_r  <= in_tuser;
      s1_word_r <= in_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // register file: bank a takes instruction writes, bank b landing loads
  assign rd_src = exec ? s1_word_r[25:16] : held_r[25:16];
  assign ra_s   = rd_src[2*IW-1:IW];
  assign ra_t   = rd_src[IW-1:0];

  assign land_en = exec && (dl_t_r != '0);
  assign inst_en = exec && wr_en && (wr_idx != '0);

  mips_eu_ram #(.WIDTH(XL), .DEPTH(mips_eu_pkg::REG_COUNT)) u_bank_a (
    .clk    (clk),
    .we     (inst_en),
    .waddr  (wr_idx),
    .wdata  (wr_val),
    .raddr0 (ra_s),
    .raddr1 (ra_t),
    .rdata0 (rda_s),
    .rdata1 (rda_t)
  );

  mips_eu_ram #(.WIDTH(XL), .DEPTH(mips_eu_pkg::REG_COUNT)) u_bank_b (
    .clk    (clk),
    .we     (land_en),
    .waddr  (dl_t_r),
    .wdata  (dl_v_r),
    .raddr0 (ra_s),
    .raddr1 (ra_t),
    .rdata0 (rdb_s),
    .rdata1 (rdb_t)
  );

  assign fa_v_nxt = inst_en;
  assign fb_v_nxt = land_en;

  always_ff @(posedge clk) begin
    rs_vld_r <= vld_r[ra_s];
    rs_lvt_r <= lvt_r[ra_s];
    rt_vld_r <= vld_r[ra_t];
    rt_lvt_r <= lvt_r[ra_t];
    fa_idx_r <= wr_idx;
    fa_val_r <= wr_val;
    fb_idx_r <= dl_t_r;
    fb_val_r <= dl_v_r;
  end

  // the last step's writes are not yet in the read data: instruction write first
  function automatic logic [XL-1:0] operand(
    input logic [IW-1:0] idx,
    input logic          vld,
    input logic          lvt,
    input logic [XL-1:0] da,
    input logic [XL-1:0] db,
    input logic          fav,
    input logic [IW-1:0] faidx,
    input logic [XL-1:0] faval,
    input logic          fbv,
    input logic [IW-1:0] fbidx,
    input logic [XL-1:0] fbval
  );
    logic [XL-1:0] v;
    if (fav && (faidx == idx)) begin
      v = faval;
    end else if (fbv && (fbidx == idx)) begin
      v = fbval;
    end else if (!vld) begin
      v = '0;
    end else if (lvt) begin
      v = db;
    end else begin
      v = da;
    end
    return v;
  endfunction

  assign opa = operand(rs, rs_vld_r, rs_lvt_r, rda_s, rdb_s,
                       fa_v_r, fa_idx_r, fa_val_r, fb_v_r, fb_idx_r, fb_val_r);
  assign opb = operand(rt, rt_vld_r, rt_lvt_r, rda_t, rdb_t,
                       fa_v_r, fa_idx_r, fa_val_r, fb_v_r, fb_idx_r, fb_val_r);

  // ---------------------------------------------------------------------------
  // decode and execute the held instruction
  assign op  = held_r[31:26];
  assign rs  = held_r[25:21];
  assign rt  = held_r[20:16];
  assign rd  = held_r[15:11];
  assign sa  = held_r[10:6];
  assign fn  = held_r[5:0];
  assign imm = held_r[15:0];
  assign ise = {{(XL-16){imm[15]}}, imm};

  assign pc_plus  = pc_r + XL'(4);
  assign sum_i    = opa + ise;
  assign ea       = sum_i;
  assign ovf      = (opa[XL-1] == ise[XL-1]) && (sum_i[XL-1] != opa[XL-1]);
  assign isolated = sr_r[mips_eu_pkg::ISOLATE_BIT];
  assign mis      = ((w_bytes == mips_eu_pkg::BYTES_4) && (ea[1:0] != 2'b00)) ||
                    ((w_bytes == mips_eu_pkg::BYTES_2) && ea[0]);

  always_comb begin
    unique case (op)
      mips_eu_pkg::OP_SB: w_bytes = mips_eu_pkg::BYTES_1;
      mips_eu_pkg::OP_SH: w_bytes = mips_eu_pkg::BYTES_2;
      default:            w_bytes = mips_eu_pkg::BYTES_4;
    endcase
  end

  always_comb begin
    o_status   = mips_eu_pkg::ST_DONE;
    o_fault    = mips_eu_pkg::F_NONE;
    o_bytes    = mips_eu_pkg::BYTES_NONE;
    o_addr     = '0;
    o_sdata    = '0;
    pc_nxt     = pc_plus;
    wr_en      = 1'b0;
    wr_idx     = rt;
    wr_val     = '0;
    sr_we      = 1'b0;
    load_issue = 1'b0;

    unique case (op)
      mips_eu_pkg::OP_SPECIAL: begin
        wr_en  = 1'b1;
        wr_idx = rd;
        unique case (fn)
          mips_eu_pkg::FN_ADDU: wr_val = opa + opb;
          mips_eu_pkg::FN_SLTU: wr_val = XL'(opa < opb);
          mips_eu_pkg::FN_SLL:  wr_val = opb << sa;
          mips_eu_pkg::FN_OR:   wr_val = opa | opb;
          default: begin
            wr_en    = 1'b0;
            o_status = mips_eu_pkg::ST_FAULT;
            o_fault  = mips_eu_pkg::F_UNKNOWN;
          end
        endcase
      end
      mips_eu_pkg::OP_COP0: begin
        if (rs != mips_eu_pkg::COP0_MT) begin
          o_status = mips_eu_pkg::ST_FAULT;
          o_fault  = mips_eu_pkg::F_UNKNOWN;
        end else begin
          unique case (rd)
            mips_eu_pkg::C0_SR: sr_we = 1'b1;
            mips_eu_pkg::C0_BPC, mips_eu_pkg::C0_BDA, mips_eu_pkg::C0_JUMPDEST,
            mips_eu_pkg::C0_DCIC, mips_eu_pkg::C0_BDAM, mips_eu_pkg::C0_BPCM,
            mips_eu_pkg::C0_CAUSE: begin
              if (opb != '0) begin
                o_status = mips_eu_pkg::ST_FAULT;
                o_fault  = mips_eu_pkg::F_BREAK_WR;
              end
            end
            default: begin
              o_status = mips_eu_pkg::ST_FAULT;
              o_fault  = mips_eu_pkg::F_COP0_REG;
            end
          endcase
        end
      end
      mips_eu_pkg::OP_ADDI: begin
        if (ovf) begin
          o_status = mips_eu_pkg::ST_FAULT;
          o_fault  = mips_eu_pkg::F_OVERFLOW;
        end else begin
          wr_en  = 1'b1;
          wr_val = sum_i;
        end
      end
      mips_eu_pkg::OP_BNE: begin
        if (opa != opb) begin
          pc_nxt = pc_r + {ise[XL-3:0], 2'b00};
        end
      end
      mips_eu_pkg::OP_J: begin
        pc_nxt = {pc_r[XL-1:XL-4], held_r[25:0], 2'b00};
      end
      mips_eu_pkg::OP_JAL: begin
        wr_en  = 1'b1;
        wr_idx = IW'(31);
        wr_val = pc_plus;
        pc_nxt = {pc_r[XL-1:XL-4], held_r[25:0], 2'b00};
      end
      mips_eu_pkg::OP_ADDIU: begin
        wr_en  = 1'b1;
        wr_val = sum_i;
      end
      mips_eu_pkg::OP_LUI: begin
        wr_en  = 1'b1;
        wr_val = {imm, 16'h0000};
      end
      mips_eu_pkg::OP_ORI: begin
        wr_en  = 1'b1;
        wr_val = opa | {16'h0000, imm};
      end
      mips_eu_pkg::OP_ANDI: begin
        wr_en  = 1'b1;
        wr_val = opa & {16'h0000, imm};
      end
      mips_eu_pkg::OP_SW, mips_eu_pkg::OP_SH, mips_eu_pkg::OP_SB, mips_eu_pkg::OP_LW: begin
        // cache isolated: memory instructions do nothing
        if (!isolated) begin
          o_addr = ea;
          if (mis) begin
            o_status = mips_eu_pkg::ST_FAULT;
            o_fault  = mips_eu_pkg::F_UNALIGNED;
          end else begin
            o_bytes = w_bytes;
            if (op == mips_eu_pkg::OP_LW) begin
              o_status   = mips_eu_pkg::ST_LOAD;
              load_issue = 1'b1;
            end else begin
              o_status = mips_eu_pkg::ST_STORE;
              unique case (w_bytes)
                mips_eu_pkg::BYTES_1: o_sdata = {24'h0, opb[7:0]};
                mips_eu_pkg::BYTES_2: o_sdata = {16'h0, opb[15:0]};
                default:              o_sdata = opb;
              endcase
            end
          end
        end
      end
      default: begin
        o_status = mips_eu_pkg::ST_FAULT;
        o_fault  = mips_eu_pkg::F_UNKNOWN;
      end
    endcase
    o_fetch = pc_nxt;
  end

  // ---------------------------------------------------------------------------
  // state update
  always_comb begin
    held_nxt   = held_r;
    sr_nxt     = sr_r;
    dl_t_nxt   = dl_t_r;
    dl_v_nxt   = dl_v_r;
    pend_t_nxt = pend_t_r;
    pend_nxt   = pend_r;
    vld_nxt    = vld_r;
    lvt_nxt    = lvt_r;
    if (exec) begin
      held_nxt = s1_word_r;
      dl_t_nxt = '0;
      dl_v_nxt = '0;
      pend_nxt = load_issue;
      if (load_issue) begin
        pend_t_nxt = rt;
      end
      if (sr_we) begin
        sr_nxt = opb;
      end
      // landing load first, the instruction's own write wins
      if (land_en) begin
        vld_nxt[dl_t_r] = 1'b1;
        lvt_nxt[dl_t_r] = 1'b1;
      end
      if (inst_en) begin
        vld_nxt[wr_idx] = 1'b1;
        lvt_nxt[wr_idx] = 1'b0;
      end
    end else if (deliver && pend_r) begin
      dl_t_nxt = pend_t_r;
      dl_v_nxt = s1_word_r;
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      pc_r     <= mips_eu_pkg::RESET_PC;
      sr_r     <= '0;
      held_r   <= '0;
      dl_t_r   <= '0;
      dl_v_r   <= '0;
      pend_t_r <= '0;
      pend_r   <= 1'b0;
      vld_r    <= '0;
      lvt_r    <= '0;
      fa_v_r   <= 1'b0;
      fb_v_r   <= 1'b0;
    end else begin
      s1_v_r   <= s1_v_nxt;
      out_v_r  <= out_v_nxt;
      pc_r     <= exec ? pc_nxt : pc_r;
      sr_r     <= sr_nxt;
      held_r   <= held_nxt;
      dl_t_r   <= dl_t_nxt;
      dl_v_r   <= dl_v_nxt;
      pend_t_r <= pend_t_nxt;
      pend_r   <= pend_nxt;
      vld_r    <= vld_nxt;
      lvt_r    <= lvt_nxt;
      fa_v_r   <= fa_v_nxt;
      fb_v_r   <= fb_v_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_act_r) begin
        out_status_r <= mips_eu_pkg::ST_DONE;
        out_fault_r  <= mips_eu_pkg::F_NONE;
        out_bytes_r  <= mips_eu_pkg::BYTES_NONE;
        out_addr_r   <= '0;
        out_sdata_r  <= '0;
        out_fetch_r  <= pc_r;
      end else begin
        out_status_r <= o_status;
        out_fault_r  <= o_fault;
        out_bytes_r  <= o_bytes;
        out_addr_r   <= o_addr;
        out_sdata_r  <= o_sdata;
        out_fetch_r  <= o_fetch;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_fault_r, out_fetch_r, out_sdata_r, out_addr_r, out_bytes_r};

  // ---------------------------------------------------------------------------
  // checks
  a_zero_reg_never_written: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0])
    else $error("register zero marked as written");

  a_pc_word_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r[1:0] == 2'b00)
    else $error("program counter lost word alignment");

  a_fault_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_status_r == mips_eu_pkg::ST_FAULT) |-> out_fault_r != mips_eu_pkg::F_NONE)
    else $error("fault result without a fault code");

  a_pending_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_status_r == mips_eu_pkg::ST_LOAD)
    else $error("load pending but last result was not a load request");

  a_done_has_no_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_status_r == mips_eu_pkg::ST_DONE) |-> out_bytes_r == mips_eu_pkg::BYTES_NONE)
    else $error("done result reports a memory access");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking bench for the MIPS R3000 subset execute unit: a queued driver,
// a clocked monitor and a cycle-free predictor of the architectural state.
// Depends on mips_eu_pkg and mips_r3000_subset_execute_unit.
`timescale 1ns / 100ps

module tb;

  localparam int RANDOM_ITEMS   = 950;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_DRAIN      = 20;

  typedef struct {
    logic        act;
    logic [31:0] word;
    bit          drain;
  } step_item_t;

  typedef struct {
    mips_eu_pkg::status_t st;
    logic [2:0]           nbytes;
    logic [31:0]          addr;
    logic [31:0]          sdata;
    logic [31:0]          fetch;
    mips_eu_pkg::fault_t  fault;
  } core_result_t;

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata   = '0;
  logic         in_tuser   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic [1:0]   out_tuser;

  mips_r3000_subset_execute_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // architectural copy of the core
  logic [31:0] gpr [32] = '{default: '0};
  logic [31:0] pc_q     = mips_eu_pkg::RESET_PC;
  logic [31:0] sr_q     = '0;
  logic [31:0] held_w   = '0;
  logic [4:0]  dly_tgt  = '0;
  logic [31:0] dly_val  = '0;
  logic [4:0]  pend_tgt = '0;
  logic        pend_ld  = 1'b0;

  step_item_t   step_queue [$];
  core_result_t pending_results [$];

  int unsigned errors = 0;
  int unsigned predicted_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned n_steps = 0, n_replies = 0, n_store = 0, n_load = 0, n_fault = 0;
  int unsigned idle_cycles = 0;
  int unsigned in_gap = 0, out_stall = 0, stall_nxt;
  bit          in_burst = 1'b0, out_burst = 1'b0;
  bit          drain_next = 1'b0, lw_in_flight = 1'b0;
  int unsigned reply_pct = 100;
  step_item_t   drv_item;
  core_result_t mon_exp;

  task automatic predict_step(input logic act, input logic [31:0] w);
    core_result_t r;
    logic [31:0]  ins, a, b, ise, slot, ld_v, sum, ea, wr_val;
    logic [5:0]   op, fn;
    logic [4:0]   rs, rt, rd, sh, ld_t, wr_idx;
    logic [15:0]  imm;
    logic [2:0]   nb;
    logic         wr, misalign;
    r = '{mips_eu_pkg::ST_DONE, mips_eu_pkg::BYTES_NONE, '0, '0, '0, mips_eu_pkg::F_NONE};
    if (act) begin
      if (pend_ld) begin
        dly_tgt = pend_tgt;
        dly_val = w;
        pend_ld = 1'b0;
      end
    end else begin
      pend_ld = 1'b0;
      ins     = held_w;
      held_w  = w;
      pc_q    = pc_q + 32'd4;
      slot    = pc_q - 32'd4;
      ld_t    = dly_tgt;
      ld_v    = dly_val;
      dly_tgt = '0;
      dly_val = '0;
      op  = ins[31:26];
      rs  = ins[25:21];
      rt  = ins[20:16];
      rd  = ins[15:11];
      sh  = ins[10:6];
      fn  = ins[5:0];
      imm = ins[15:0];
      ise = {{16{imm[15]}}, imm};
      a   = gpr[rs];
      b   = gpr[rt];
      wr  = 1'b0;
      wr_idx = '0;
      wr_val = '0;
      case (op)
        mips_eu_pkg::OP_SPECIAL: begin
          wr     = 1'b1;
          wr_idx = rd;
          case (fn)
            mips_eu_pkg::FN_ADDU: wr_val = a + b;
            mips_eu_pkg::FN_SLTU: wr_val = (a < b) ? 32'd1 : 32'd0;
            mips_eu_pkg::FN_SLL:  wr_val = b << sh;
            mips_eu_pkg::FN_OR:   wr_val = a | b;
            default: begin
              wr    = 1'b0;
              r.st  = mips_eu_pkg::ST_FAULT;
              r.fault = mips_eu_pkg::F_UNKNOWN;
            end
          endcase
        end
        mips_eu_pkg::OP_COP0: begin
          if (rs != mips_eu_pkg::COP0_MT) begin
            r.st    = mips_eu_pkg::ST_FAULT;
            r.fault = mips_eu_pkg::F_UNKNOWN;
          end else begin
            case (rd)
              mips_eu_pkg::C0_SR: sr_q = b;
              mips_eu_pkg::C0_BPC, mips_eu_pkg::C0_BDA, mips_eu_pkg::C0_JUMPDEST,
              mips_eu_pkg::C0_DCIC, mips_eu_pkg::C0_BDAM, mips_eu_pkg::C0_BPCM,
              mips_eu_pkg::C0_CAUSE: begin
                if (b != '0) begin
                  r.st    = mips_eu_pkg::ST_FAULT;
                  r.fault = mips_eu_pkg::F_BREAK_WR;
                end
              end
              default: begin
                r.st    = mips_eu_pkg::ST_FAULT;
                r.fault = mips_eu_pkg::F_COP0_REG;
              end
            endcase
          end
        end
        mips_eu_pkg::OP_ADDI: begin
          sum = a + ise;
          // signed overflow: operands agree in sign, sum does not
          if (a[31] == ise[31] && sum[31] != a[31]) begin
            r.st    = mips_eu_pkg::ST_FAULT;
            r.fault = mips_eu_pkg::F_OVERFLOW;
          end else begin
            wr = 1'b1; wr_idx = rt; wr_val = sum;
          end
        end
        mips_eu_pkg::OP_BNE: if (a != b) pc_q = slot + (ise << 2);
        mips_eu_pkg::OP_J:   pc_q = {slot[31:28], ins[25:0], 2'b00};
        mips_eu_pkg::OP_JAL: begin
          wr = 1'b1; wr_idx = 5'd31; wr_val = pc_q;
          pc_q = {slot[31:28], ins[25:0], 2'b00};
        end
        mips_eu_pkg::OP_ADDIU: begin wr = 1'b1; wr_idx = rt; wr_val = a + ise; end
        mips_eu_pkg::OP_LUI: begin wr = 1'b1; wr_idx = rt; wr_val = {imm, 16'h0000}; end
        mips_eu_pkg::OP_ORI: begin wr = 1'b1; wr_idx = rt; wr_val = a | {16'h0000, imm}; end
        mips_eu_pkg::OP_ANDI: begin wr = 1'b1; wr_idx = rt; wr_val = a & {16'h0000, imm}; end
        mips_eu_pkg::OP_SW, mips_eu_pkg::OP_SH, mips_eu_pkg::OP_SB, mips_eu_pkg::OP_LW: begin
          ea = a + ise;
          nb = (op == mips_eu_pkg::OP_SB) ? mips_eu_pkg::BYTES_1 :
               (op == mips_eu_pkg::OP_SH) ? mips_eu_pkg::BYTES_2 : mips_eu_pkg::BYTES_4;
          misalign = (op == mips_eu_pkg::OP_SB) ? 1'b0 :
                     (op == mips_eu_pkg::OP_SH) ? ea[0] : (ea[1:0] != 2'b00);
          // isolated cache swallows the access, alignment included
          if (!sr_q[mips_eu_pkg::ISOLATE_BIT]) begin
            if (misalign) begin
              r.st    = mips_eu_pkg::ST_FAULT;
              r.fault = mips_eu_pkg::F_UNALIGNED;
              r.addr  = ea;
            end else begin
              r.addr   = ea;
              r.nbytes = nb;
              if (op == mips_eu_pkg::OP_LW) begin
                r.st     = mips_eu_pkg::ST_LOAD;
                pend_ld  = 1'b1;
                pend_tgt = rt;
              end else begin
                r.st    = mips_eu_pkg::ST_STORE;
                r.sdata = (nb == mips_eu_pkg::BYTES_4) ? b :
                          (nb == mips_eu_pkg::BYTES_2) ? {16'h0000, b[15:0]} :
                                                         {24'h000000, b[7:0]};
              end
            end
          end
        end
        default: begin
          r.st    = mips_eu_pkg::ST_FAULT;
          r.fault = mips_eu_pkg::F_UNKNOWN;
        end
      endcase
      // landing load first, the instruction's own write wins
      if (ld_t != '0) gpr[ld_t] = ld_v;
      if (wr && wr_idx != '0) gpr[wr_idx] = wr_val;
    end
    r.fetch = pc_q;
    pending_results.push_back(r);
    predicted_cnt++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sh, logic [5:0] fn);
    return {mips_eu_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_mtc0(logic [4:0] rt, logic [4:0] rd);
    return {mips_eu_pkg::OP_COP0, mips_eu_pkg::COP0_MT, rt, rd, 11'h000};
  endfunction

  function automatic logic [4:0] pick_reg();
    // a small working set makes hazards between neighbours frequent
    return ($urandom_range(0, 9) < 6) ? 5'($urandom_range(0, 7)) : 5'($urandom);
  endfunction

  function automatic logic [31:0] rand_data();
    int unsigned k;
    k = $urandom_range(0, 9);
    return (k == 0) ? 32'h0000_0000 : (k == 1) ? 32'hFFFF_FFFF : $urandom;
  endfunction

  function automatic logic [31:0] rand_insn();
    int unsigned k;
    logic [5:0]  op, fn;
    logic [15:0] imm;
    logic [4:0]  rd, rt;
    k = $urandom_range(0, 99);
    if (k < 6) return $urandom;
    if (k < 30) begin
      case ($urandom_range(0, 3))
        0:       fn = mips_eu_pkg::FN_ADDU;
        1:       fn = mips_eu_pkg::FN_SLTU;
        2:       fn = mips_eu_pkg::FN_SLL;
        default: fn = mips_eu_pkg::FN_OR;
      endcase
      return enc_r(pick_reg(), pick_reg(), pick_reg(), 5'($urandom), fn);
    end
    if (k < 33) return enc_r(pick_reg(), pick_reg(), pick_reg(), 5'($urandom), 6'($urandom));
    if (k < 52) begin
      case ($urandom_range(0, 4))
        0:       op = mips_eu_pkg::OP_ADDI;
        1:       op = mips_eu_pkg::OP_ADDIU;
        2:       op = mips_eu_pkg::OP_ANDI;
        3:       op = mips_eu_pkg::OP_ORI;
        default: op = mips_eu_pkg::OP_LUI;
      endcase
      imm = 16'($urandom);
      if (op == mips_eu_pkg::OP_ADDI && $urandom_range(0, 3) == 0)
        imm = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      return enc_i(op, pick_reg(), pick_reg(), imm);
    end
    if (k < 57) return enc_i(mips_eu_pkg::OP_BNE, pick_reg(), pick_reg(), 16'($urandom));
    if (k < 59) return {mips_eu_pkg::OP_J, 26'($urandom)};
    if (k < 61) return {mips_eu_pkg::OP_JAL, 26'($urandom)};
    if (k < 86) begin
      case ($urandom_range(0, 3))
        0:       op = mips_eu_pkg::OP_SW;
        1:       op = mips_eu_pkg::OP_SH;
        2:       op = mips_eu_pkg::OP_SB;
        default: op = mips_eu_pkg::OP_LW;
      endcase
      imm = 16'($urandom);
      if ($urandom_range(0, 4) != 0) imm[1:0] = 2'b00;
      return enc_i(op, ($urandom_range(0, 9) < 4) ? 5'd0 : pick_reg(), pick_reg(), imm);
    end
    if (k < 96) begin
      k = $urandom_range(0, 9);
      if (k < 3) rd = mips_eu_pkg::C0_SR;
      else if (k < 7) begin
        case ($urandom_range(0, 6))
          0:       rd = mips_eu_pkg::C0_BPC;
          1:       rd = mips_eu_pkg::C0_BDA;
          2:       rd = mips_eu_pkg::C0_JUMPDEST;
          3:       rd = mips_eu_pkg::C0_DCIC;
          4:       rd = mips_eu_pkg::C0_BDAM;
          5:       rd = mips_eu_pkg::C0_BPCM;
          default: rd = mips_eu_pkg::C0_CAUSE;
        endcase
      end else rd = 5'($urandom);
      rt = ($urandom_range(0, 9) < 6) ? 5'd0 : pick_reg();
      return enc_mtc0(rt, rd);
    end
    return {mips_eu_pkg::OP_COP0, 5'($urandom), 5'($urandom), 5'($urandom), 11'($urandom)};
  endfunction

  task automatic push_item(input logic act, input logic [31:0] w);
    step_queue.push_back('{act, w, drain_next});
    drain_next = 1'b0;
  endtask

  // a load is executed one step after its word is fed; its data follows that step
  task automatic add_exec(input logic [31:0] w);
    push_item(1'b0, w);
    if (lw_in_flight) begin
      lw_in_flight = 1'b0;
      if ($urandom_range(0, 99) < reply_pct) push_item(1'b1, rand_data());
    end
    if (w[31:26] == mips_eu_pkg::OP_LW) lw_in_flight = 1'b1;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_step(in_tuser, in_tdata);
        if (in_tuser) n_replies++;
        else n_steps++;
      end
      if (in_tvalid && !in_tready) begin
        // hold the transaction
      end else if (in_gap != 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (step_queue.size() != 0 &&
                   !(step_queue[0].drain && predicted_cnt != checked_cnt)) begin
        drv_item = step_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= drv_item.word;
        in_tuser  <= drv_item.act;
        if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
        in_gap <= in_burst ? 0 : $urandom_range(0, 9);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else begin
      stall_nxt = out_stall;
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result with no prediction: status %0d tdata %h", out_tuser, out_tdata);
          errors++;
        end else begin
          mon_exp = pending_results.pop_front();
          compare_field("status", 32'(mon_exp.st), 32'(out_tuser));
          compare_field("access_bytes", 32'(mon_exp.nbytes), 32'(out_tdata[2:0]));
          compare_field("address", mon_exp.addr, out_tdata[34:3]);
          compare_field("store_data", mon_exp.sdata, out_tdata[66:35]);
          compare_field("fetch_address", mon_exp.fetch, out_tdata[98:67]);
          compare_field("fault_code", 32'(mon_exp.fault), 32'(out_tdata[101:99]));
          compare_field("tdata padding", 32'd0, 32'(out_tdata[103:102]));
          case (mon_exp.st)
            mips_eu_pkg::ST_STORE: n_store++;
            mips_eu_pkg::ST_LOAD:  n_load++;
            mips_eu_pkg::ST_FAULT: n_fault++;
            default:  ;
          endcase
        end
        checked_cnt <= checked_cnt + 1;
        if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
        stall_nxt = out_burst ? 0 : $urandom_range(0, 9);
      end
      if (stall_nxt != 0) begin
        out_tready <= 1'b0;
        out_stall  <= stall_nxt - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int unsigned base, it;
    bit          timed_out;
    timed_out = 1'b0;

    // directed: arithmetic edges, every access width, load timing, cop0 cases
    add_exec(enc_i(mips_eu_pkg::OP_LUI, 5'd0, 5'd1, 16'h7FFF));
    add_exec(enc_i(mips_eu_pkg::OP_ORI, 5'd1, 5'd1, 16'hFFFF));
    add_exec(enc_i(mips_eu_pkg::OP_ADDI, 5'd1, 5'd2, 16'h0001));     // positive overflow
    add_exec(enc_i(mips_eu_pkg::OP_ADDIU, 5'd1, 5'd3, 16'h0001));
    add_exec(enc_i(mips_eu_pkg::OP_ADDI, 5'd3, 5'd4, 16'hFFFF));     // negative overflow
    add_exec(enc_r(5'd1, 5'd3, 5'd5, 5'd0, mips_eu_pkg::FN_ADDU));
    add_exec(enc_r(5'd1, 5'd3, 5'd6, 5'd0, mips_eu_pkg::FN_SLTU));
    add_exec(enc_r(5'd0, 5'd1, 5'd7, 5'd31, mips_eu_pkg::FN_SLL));
    add_exec(enc_r(5'd1, 5'd3, 5'd8, 5'd0, mips_eu_pkg::FN_OR));
    add_exec(enc_i(mips_eu_pkg::OP_ANDI, 5'd3, 5'd9, 16'hFFFF));
    add_exec(enc_i(mips_eu_pkg::OP_SW, 5'd0, 5'd1, 16'h0000));
    add_exec(enc_i(mips_eu_pkg::OP_SH, 5'd0, 5'd1, 16'h0002));
    add_exec(enc_i(mips_eu_pkg::OP_SB, 5'd0, 5'd1, 16'hFFFF));
    add_exec(enc_i(mips_eu_pkg::OP_SW, 5'd0, 5'd1, 16'h0002));
    add_exec(enc_i(mips_eu_pkg::OP_SH, 5'd0, 5'd1, 16'h0001));
    add_exec(enc_i(mips_eu_pkg::OP_LW, 5'd0, 5'd10, 16'h0004));
    add_exec(enc_r(5'd10, 5'd0, 5'd11, 5'd0, mips_eu_pkg::FN_ADDU)); // delay slot sees old value
    add_exec(enc_r(5'd10, 5'd0, 5'd12, 5'd0, mips_eu_pkg::FN_ADDU));
    add_exec(enc_i(mips_eu_pkg::OP_LW, 5'd3, 5'd10, 16'h0001));      // unaligned, reply ignored
    add_exec(enc_i(mips_eu_pkg::OP_LW, 5'd0, 5'd13, 16'h0008));
    add_exec(enc_i(mips_eu_pkg::OP_ORI, 5'd0, 5'd13, 16'h00AA));     // overrides landing load
    add_exec(enc_r(5'd13, 5'd0, 5'd14, 5'd0, mips_eu_pkg::FN_ADDU));
    reply_pct = 0;
    add_exec(enc_i(mips_eu_pkg::OP_LW, 5'd0, 5'd15, 16'h000C));      // never answered, dropped
    add_exec(enc_r(5'd15, 5'd0, 5'd16, 5'd0, mips_eu_pkg::FN_ADDU));
    reply_pct = 100;
    add_exec(enc_mtc0(5'd0, mips_eu_pkg::C0_BPC));
    add_exec(enc_mtc0(5'd1, mips_eu_pkg::C0_CAUSE));
    add_exec(enc_mtc0(5'd1, 5'd1));
    add_exec({mips_eu_pkg::OP_COP0, 5'd0, 5'd1, mips_eu_pkg::C0_SR, 11'h000});
    add_exec(enc_r(5'd1, 5'd1, 5'd1, 5'd0, 6'h3F));
    add_exec(32'hFFFF_FFFF);
    add_exec(enc_i(mips_eu_pkg::OP_BNE, 5'd1, 5'd0, 16'hFFFF));
    add_exec({mips_eu_pkg::OP_J, 26'h3FF_FFFF});
    add_exec({mips_eu_pkg::OP_JAL, 26'h000_0000});
    drain_next = 1'b1;
    add_exec(enc_i(mips_eu_pkg::OP_LUI, 5'd0, 5'd17, 16'h0001));
    add_exec(enc_mtc0(5'd17, mips_eu_pkg::C0_SR));                   // isolate cache
    add_exec(enc_i(mips_eu_pkg::OP_SW, 5'd0, 5'd1, 16'h0001));
    add_exec(enc_i(mips_eu_pkg::OP_LW, 5'd0, 5'd18, 16'h0000));
    add_exec(enc_mtc0(5'd0, mips_eu_pkg::C0_SR));

    base = step_queue.size();
    reply_pct = 85;
    for (it = 0; step_queue.size() - base < RANDOM_ITEMS; it++) begin
      if (it % 180 == 179) drain_next = 1'b1;
      if ($urandom_range(0, 99) < 2) begin
        add_exec(enc_i(mips_eu_pkg::OP_LUI, 5'd0, 5'd9, {15'($urandom), 1'b1}));
        add_exec(enc_mtc0(5'd9, mips_eu_pkg::C0_SR));
      end else if ($urandom_range(0, 99) < 3) begin
        push_item(1'b1, rand_data());
      end else begin
        add_exec(rand_insn());
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (!(step_queue.size() == 0 && !in_tvalid && pending_results.size() == 0) &&
           !timed_out) begin
      @(negedge clk);
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end
    if (timed_out) begin
      $error("no transaction for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_results.size());
      errors++;
    end
    repeat (END_DRAIN) @(posedge clk);

    $display("sent %0d execute steps and %0d load replies; checked %0d results",
             n_steps, n_replies, checked_cnt);
    $display("of those %0d stores, %0d load requests, %0d faults; %0d mismatches",
             n_store, n_load, n_fault, errors);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
